// File: rtl/core/chaocipher_engine_top_defines.svh
// Assertion macros used by the chaocipher engine sequencer
`ifndef CHAOCIPHER_ENGINE_TOP_DEFINES_SVH
`define CHAOCIPHER_ENGINE_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define CHC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define CHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/chc_pkg.sv
// Types, key alphabets and permutation wiring for the chaocipher engine
`timescale 1ns / 1ps

package chc_pkg;

   localparam int ALPHA_SIZE = 26;
   localparam int LETTER_W   = $clog2(ALPHA_SIZE);

   typedef logic [LETTER_W-1:0] letter_type;
   typedef letter_type          alpha_type [ALPHA_SIZE];

   localparam logic [7:0] ASCII_UPPER_A = 8'd65;
   localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [7:0] ASCII_LOWER_A = 8'd97;
   localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
   localparam logic [7:0] ASCII_CASE    = 8'd32;

   // HXUCZVAMDSLKPEFJRIGTWOBNYQ
   localparam alpha_type LEFT_KEY = '{
      5'd7, 5'd23, 5'd20, 5'd2, 5'd25, 5'd21, 5'd0, 5'd12, 5'd3, 5'd18,
      5'd11, 5'd10, 5'd15, 5'd4, 5'd5, 5'd9, 5'd17, 5'd8, 5'd6, 5'd19,
      5'd22, 5'd14, 5'd1, 5'd13, 5'd24, 5'd16};

   // PTLNBQDEOYSFAVZKGJRIHWXUMC
   localparam alpha_type RIGHT_KEY = '{
      5'd15, 5'd19, 5'd11, 5'd13, 5'd1, 5'd16, 5'd3, 5'd4, 5'd14, 5'd24,
      5'd18, 5'd5, 5'd0, 5'd21, 5'd25, 5'd10, 5'd6, 5'd9, 5'd17, 5'd8,
      5'd7, 5'd22, 5'd23, 5'd20, 5'd12, 5'd2};

   localparam int LEFT_RUN   = 12;
   localparam int RIGHT_RUN  = 11;
   localparam int NADIR_NEXT = 14;
   localparam int RIGHT_TAIL = 25;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_ROTATE,
      OP_PERMUTE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // Source cell of each left letter during the permute step
   function automatic int left_perm_src(input int i);
      int src;
      if (i >= 1 && i <= LEFT_RUN) begin
         src = i + 1;
      end else if (i == LEFT_RUN + 1) begin
         src = 1;
      end else begin
         src = i;
      end
      return src;
   endfunction

   // Source cell of each right letter: shift by one, then pluck the third
   function automatic int right_perm_src(input int i);
      int src;
      if (i < 2) begin
         src = i + 1;
      end else if (i < NADIR_NEXT - 1) begin
         src = i + 2;
      end else if (i == NADIR_NEXT - 1) begin
         src = 3;
      end else if (i < RIGHT_TAIL) begin
         src = i + 1;
      end else begin
         src = 0;
      end
      return src;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) ||
             ((c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z));
   endfunction

   function automatic letter_type letter_of(input logic [7:0] c);
      logic [7:0] up;
      up = (c >= ASCII_LOWER_A) ? (c - ASCII_CASE) : c;
      return LETTER_W'(up - ASCII_UPPER_A);
   endfunction

   function automatic logic [6:0] ascii_of(input letter_type l);
      return 7'(ASCII_UPPER_A) + 7'(l);
   endfunction

endpackage

// File: rtl/core/chaocipher_engine_top.sv
// Chaocipher engine: ring of 26 letter cells with a search and permute sequencer
//
//   channel  direction  ports                            word
//   req      in         req_valid/ready                  char_code[8], restart[1]
//   rsp      out        rsp_valid/ready                  out_char[7]
//   csr      in         csr_valid/ready                  decode_mode[1]
//
// A letter is rotated k = 0..25 times until it reaches the zenith cell, then permuted;
// the ring rotates a single step at a time. Non-letters give no word.
// Synchronous reset loads the key alphabets and clears decode mode.
// A held result stalls the permute step; a new word is still taken while the result waits.
`timescale 1ns / 1ps

module chaocipher_engine_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_decode_mode
);
   import chc_pkg::*;

   letter_type   ring_l [ALPHA_SIZE];
   letter_type   ring_r [ALPHA_SIZE];
   cell_ctl_type ctl;

   for (genvar i = 0; i < ALPHA_SIZE; i++) begin : g_cell
      chc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .key_l (LEFT_KEY[i]),
         .key_r (RIGHT_KEY[i]),
         .nxt_l (ring_l[(i + 1) % ALPHA_SIZE]),
         .nxt_r (ring_r[(i + 1) % ALPHA_SIZE]),
         .prm_l (ring_l[left_perm_src(i)]),
         .prm_r (ring_r[right_perm_src(i)]),
         .cur_l (ring_l[i]),
         .cur_r (ring_r[i])
      );
   end

   chc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_decode_mode (csr_decode_mode),
      .zen_l           (ring_l[0]),
      .zen_r           (ring_r[0]),
      .ctl             (ctl)
   );

endmodule

// File: rtl/core/chc_cell.sv
// One ring cell holding a left and a right alphabet letter
`timescale 1ns / 1ps

module chc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  chc_pkg::cell_ctl_type ctl,
   input  chc_pkg::letter_type  key_l,
   input  chc_pkg::letter_type  key_r,
   input  chc_pkg::letter_type  nxt_l,
   input  chc_pkg::letter_type  nxt_r,
   input  chc_pkg::letter_type  prm_l,
   input  chc_pkg::letter_type  prm_r,
   output chc_pkg::letter_type  cur_l,
   output chc_pkg::letter_type  cur_r
);
   import chc_pkg::*;

   letter_type l_ff, l_in;
   letter_type r_ff, r_in;

   always_comb begin
      case (ctl.op)
         OP_HOLD: begin
            l_in = l_ff;
            r_in = r_ff;
         end
         OP_LOAD: begin
            l_in = key_l;
            r_in = key_r;
         end
         OP_ROTATE: begin
            l_in = nxt_l;
            r_in = nxt_r;
         end
         OP_PERMUTE: begin
            l_in = prm_l;
            r_in = prm_r;
         end
         default: begin
            l_in = l_ff;
            r_in = r_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_ff <= key_l;
         r_ff <= key_r;
      end else begin
         l_ff <= l_in;
         r_ff <= r_in;
      end
   end

   assign cur_l = l_ff;
   assign cur_r = r_ff;

endmodule

// File: rtl/core/chc_ctrl.sv
// Sequencer: word intake, zenith search, permute and result register
`timescale 1ns / 1ps
`include "chaocipher_engine_top_defines.svh"

module chc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic                  req_restart,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_out_char,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_decode_mode,
   input  chc_pkg::letter_type   zen_l,
   input  chc_pkg::letter_type   zen_r,
   output chc_pkg::cell_ctl_type ctl
);
   import chc_pkg::*;

   state_type  state_ff, state_in;
   letter_type letter_ff, letter_in;
   logic       mode_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic [LETTER_W-1:0] rot_cnt_ff, rot_cnt_in;

   letter_type search_l;
   letter_type other_l;
   logic       match;
   logic       out_free;
   logic       accept;

   assign search_l  = mode_ff ? zen_l : zen_r;
   assign other_l   = mode_ff ? zen_r : zen_l;
   assign match     = (search_l == letter_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      letter_in    = letter_ff;
      rot_cnt_in   = rot_cnt_ff;
      out_char_in  = out_char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl.op       = OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  ctl.op = OP_LOAD;
               end
               letter_in  = letter_of(req_char_code);
               rot_cnt_in = '0;
               if (is_letter(req_char_code)) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (!match) begin
               ctl.op     = OP_ROTATE;
               rot_cnt_in = rot_cnt_ff + 1'b1;
            end else if (out_free) begin
               ctl.op       = OP_PERMUTE;
               out_char_in  = ascii_of(other_l);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         rot_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rot_cnt_ff   <= rot_cnt_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_decode_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      letter_ff   <= letter_in;
      out_char_ff <= out_char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;

   `CHC_ASSERT(a_rot_bound, (state_ff != ST_SEARCH) || (rot_cnt_ff < LETTER_W'(ALPHA_SIZE)), "letter not found within one turn")
   `CHC_ASSERT(a_perm_free, (ctl.op != OP_PERMUTE) || (out_free && match), "permute without match or free output")
   `CHC_ASSERT_NEXT(a_perm_done, ctl.op == OP_PERMUTE, (state_ff == ST_IDLE) && rsp_valid_ff, "result not posted after permute")

endmodule
